// ===== design/lla_pkg.sv =====
// Shared types and constants for the least loaded bin assigner.
// No dependencies; every other design file imports this package.
package lla_pkg;

	localparam int WEIGHT_W = 16;
	localparam int BIN_W    = 4;
	localparam int REPORT_W = 32;
	localparam int COUNT_W  = 5;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [BIN_W-1:0]    bin_t;
	typedef logic [REPORT_W-1:0] report_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam count_t COUNT_RESET = count_t'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} scan_state_t;

	// Control that the sequencer hands to every cell of the ring.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== design/lla_if.sv =====
// Handshake channels of the least loaded bin assigner: job, result and configuration.
// Depends on lla_pkg for the payload types.
interface lla_job_if;
	import lla_pkg::*;

	logic    valid;
	logic    ready;
	weight_t job_weight;
	logic    start_batch;

	modport source (output valid, output job_weight, output start_batch, input ready);
	modport sink   (input valid, input job_weight, input start_batch, output ready);
endinterface

interface lla_result_if;
	import lla_pkg::*;

	logic    valid;
	logic    ready;
	bin_t    chosen_bin;
	report_t load_before;

	modport source (output valid, output chosen_bin, output load_before, input ready);
	modport sink   (input valid, input chosen_bin, input load_before, output ready);
endinterface

interface lla_cfg_if;
	import lla_pkg::*;

	logic   valid;
	logic   ready;
	count_t bin_count;

	modport source (output valid, output bin_count, input ready);
	modport sink   (input valid, input bin_count, output ready);
endinterface

// ===== design/least_loaded_bin_assigner.sv =====
// Least loaded bin assigner: bin loads circulate through a ring of cells past one comparator.
// A result is registered in the finish state once its job has been scanned across every bin of the ring.
// Jobs do not overlap: a new job request is taken only after the previous job has made one full turn of the load ring.
// A finished result waits in the output register while the next job request is taken.
// Reset clears every bin load to zero and sets bin_count to 16.
module least_loaded_bin_assigner #(
	parameter int MAX_BINS   = 16,
	parameter int LOAD_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	lla_job_if.sink      job,
	lla_result_if.source result,
	lla_cfg_if.sink      cfg
);
	import lla_pkg::*;

	count_t                bin_count_q;
	cell_ctrl_t            ctrl;
	logic [LOAD_WIDTH-1:0] loads [MAX_BINS];
	logic [LOAD_WIDTH-1:0] tail_load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			bin_count_q <= cfg.bin_count;
		end
	end

	generate
		for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
			logic [LOAD_WIDTH-1:0] next_in;
			if (i == MAX_BINS - 1) begin : g_tail
				assign next_in = tail_load;
			end else begin : g_mid
				assign next_in = loads[i+1];
			end
			lla_cell #(
				.LOAD_WIDTH (LOAD_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.load_in  (next_in),
				.load_out (loads[i])
			);
		end
	endgenerate

	lla_scan #(
		.MAX_BINS   (MAX_BINS),
		.LOAD_WIDTH (LOAD_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.result    (result),
		.bin_count (bin_count_q),
		.head_load (loads[0]),
		.tail_load (tail_load),
		.ctrl      (ctrl)
	);

	// The sequencer is busy for a whole ring turn after it takes a job request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job.valid && job.ready) |=> !job.ready)
	else $error("job request accepted while a scan was already starting");

	// A batch start empties the ring before the scan begins.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job.valid && job.ready && job.start_batch) |=>
		(loads[0] == '0 && loads[MAX_BINS-1] == '0))
	else $error("bin loads not cleared at batch start");

endmodule

// ===== design/lla_cell.sv =====
// One cell of the load ring: holds the load of one bin and passes it on.
// Depends on lla_pkg for the cell control struct.
module lla_cell #(
	parameter int LOAD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lla_pkg::cell_ctrl_t   ctrl,
	input  logic [LOAD_WIDTH-1:0] load_in,
	output logic [LOAD_WIDTH-1:0] load_out
);
	import lla_pkg::*;

	logic [LOAD_WIDTH-1:0] load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
		end else if (ctrl.clear) begin
			load_q <= '0;
		end else if (ctrl.shift) begin
			load_q <= load_in;
		end
	end

	assign load_out = load_q;

endmodule

// ===== design/lla_scan.sv =====
// Sequencer at the head of the load ring: running minimum, pending update, result register.
// Depends on lla_pkg and on the channel interfaces in lla_if.
module lla_scan #(
	parameter int MAX_BINS   = 16,
	parameter int LOAD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lla_job_if.sink               job,
	lla_result_if.source          result,
	input  lla_pkg::count_t       bin_count,
	input  logic [LOAD_WIDTH-1:0] head_load,
	output logic [LOAD_WIDTH-1:0] tail_load,
	output lla_pkg::cell_ctrl_t   ctrl
);
	import lla_pkg::*;

	localparam int IDX_W = $clog2(MAX_BINS);
	localparam int CMP_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
	localparam int SUM_W = ((LOAD_WIDTH > WEIGHT_W) ? LOAD_WIDTH : WEIGHT_W) + 1;
	localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(MAX_BINS - 1);
	localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = {LOAD_WIDTH{1'b1}};

	scan_state_t state_q, state_next;

	logic [IDX_W-1:0]      k_q;
	weight_t               weight_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [LOAD_WIDTH-1:0] best_val_q;
	logic                  pend_valid_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic [LOAD_WIDTH-1:0] pend_val_q;
	logic                  out_valid_q;
	bin_t                  out_bin_q;
	report_t               out_load_q;

	logic                  accept;
	logic                  finish_go;
	logic [LOAD_WIDTH-1:0] eff_load;
	logic                  in_range;
	logic                  take_best;
	logic [SUM_W-1:0]      sum;
	logic [LOAD_WIDTH-1:0] new_load;

	assign accept = job.valid && job.ready;

	// The previous job's update is still held here until its bin passes the head.
	assign eff_load = (pend_valid_q && (pend_idx_q == k_q)) ? pend_val_q : head_load;
	assign in_range = (k_q == '0) || (CMP_W'(k_q) < CMP_W'(bin_count));
	assign take_best = (k_q == '0) || (in_range && (eff_load < best_val_q));

	assign sum = SUM_W'(best_val_q) + SUM_W'(weight_q);
	assign new_load = (sum > SUM_W'(LOAD_MAX)) ? LOAD_MAX : sum[LOAD_WIDTH-1:0];

	assign tail_load = eff_load;

	always_comb begin
		state_next = state_q;
		job.ready = 1'b0;
		finish_go = 1'b0;
		ctrl.clear = 1'b0;
		ctrl.shift = 1'b0;
		case (state_q)
			ST_IDLE: begin
				job.ready = 1'b1;
				if (job.valid) begin
					ctrl.clear = job.start_batch;
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctrl.shift = 1'b1;
				if (k_q == LAST_IDX) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					finish_go = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept && job.start_batch) begin
				pend_valid_q <= 1'b0;
			end else if (finish_go) begin
				pend_valid_q <= 1'b1;
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q <= job.job_weight;
			k_q <= '0;
		end else if (state_q == ST_SCAN) begin
			k_q <= k_q + 1'b1;
			if (take_best) begin
				best_idx_q <= k_q;
				best_val_q <= eff_load;
			end
		end
		if (finish_go) begin
			pend_idx_q <= best_idx_q;
			pend_val_q <= new_load;
			out_bin_q <= BIN_W'(best_idx_q);
			out_load_q <= REPORT_W'(best_val_q);
		end
	end

	assign result.valid = out_valid_q;
	assign result.chosen_bin = out_bin_q;
	assign result.load_before = out_load_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for least_loaded_bin_assigner: directed and random jobs are checked against a
// behavioral prediction of the bin loads. Depends on lla_pkg, lla_if.sv and the design top.
module tb_top;
	import lla_pkg::*;

	localparam int NUM_BINS     = 16;
	localparam int RESULT_DELAY = NUM_BINS + 2;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_JOBS   = 70;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		weight_t weight;
		logic    start;
	} job_t;

	typedef struct packed {
		bin_t    bin;
		report_t load;
	} assignment_t;

	logic clk = 1'b0;
	logic arst_n;

	lla_job_if    job ();
	lla_result_if result ();
	lla_cfg_if    cfg ();

	least_loaded_bin_assigner #(
		.MAX_BINS   (NUM_BINS),
		.LOAD_WIDTH (32)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.result (result),
		.cfg    (cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [31:0] bin_load [NUM_BINS];
	count_t      bin_count_reg = COUNT_RESET;
	job_t        pending_jobs [$];
	assignment_t expected_assignments [$];

	bit job_steady   = 1'b0;
	bit rx_steady    = 1'b0;
	bit job_taken    = 1'b0;
	bit result_taken = 1'b0;
	bit hold_request = 1'b0;
	int job_wait     = 0;
	int rx_wait      = 0;
	int hold_left    = 0;
	int cycles       = 0;
	int mismatches   = 0;
	int jobs_taken   = 0;
	int results_seen = 0;
	int settings_used = 0;

	function automatic int draw_wait(bit steady);
		if (steady)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// Clears all bins on a batch start, then picks the least loaded bin among those in use and books the weight on it.
	function automatic assignment_t assign_least_loaded(weight_t weight, logic start);
		int          span;
		int          best;
		logic [32:0] sum;
		assignment_t pick;
		if (start) begin
			foreach (bin_load[i])
				bin_load[i] = '0;
		end
		if (bin_count_reg == 0)
			span = 1;
		else if (bin_count_reg > NUM_BINS)
			span = NUM_BINS;
		else
			span = int'(bin_count_reg);
		best = 0;
		for (int i = 1; i < span; i++) begin
			if (bin_load[i] < bin_load[best])
				best = i;
		end
		pick.bin  = bin_t'(best);
		pick.load = bin_load[best];
		sum = {1'b0, bin_load[best]} + 33'(weight);
		bin_load[best] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		return pick;
	endfunction

	function automatic weight_t random_weight();
		case ($urandom_range(0, 3))
			0: return weight_t'($urandom_range(0, 15));
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return weight_t'($urandom);
		endcase
	endfunction

	task automatic queue_job(weight_t weight, logic start);
		job_t item;
		item.weight = weight;
		item.start  = start;
		pending_jobs = {pending_jobs, item};
	endtask

	task automatic wait_idle();
		while (pending_jobs.size() != 0 || expected_assignments.size() != 0)
			@(negedge clk);
		repeat (RESULT_DELAY) @(negedge clk);
	endtask

	task automatic write_bin_count(count_t value);
		@(negedge clk);
		cfg.valid     <= 1'b1;
		cfg.bin_count <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		bin_count_reg = value;
		settings_used++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Request side: accept at the rising edge, drive the next request at the falling edge.
	always @(posedge clk) begin
		assignment_t booked;
		if (arst_n && job.valid && job.ready) begin
			booked = assign_least_loaded(job.job_weight, job.start_batch);
			expected_assignments = {expected_assignments, booked};
			pending_jobs.delete(0);
			job_taken = 1'b1;
			jobs_taken++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!job.valid || job_taken)) begin
			job_taken = 1'b0;
			if (pending_jobs.size() == 0) begin
				job.valid <= 1'b0;
			end else if (job_wait > 0) begin
				job_wait--;
				job.valid <= 1'b0;
			end else begin
				job.valid       <= 1'b1;
				job.job_weight  <= pending_jobs[0].weight;
				job.start_batch <= pending_jobs[0].start;
				if ($urandom_range(0, 39) == 0)
					job_steady = !job_steady;
				job_wait = draw_wait(job_steady);
			end
		end
	end

	// Long output stall, counted here so the result side only has to look at it.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 1'b0;
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			rx_wait = draw_wait(rx_steady);
		end
		if (!arst_n || hold_left > 0) begin
			result.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		assignment_t want;
		if (arst_n && result.valid && result.ready) begin
			result_taken = 1'b1;
			results_seen++;
			if (expected_assignments.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no job pending: bin %0d load %0d",
						$time, result.chosen_bin, result.load_before);
			end else begin
				want = expected_assignments.pop_front();
				if (result.chosen_bin !== want.bin || result.load_before !== want.load) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected bin %0d load %0d, got bin %0d load %0d",
							$time, want.bin, want.load, result.chosen_bin, result.load_before);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, expected_assignments.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		count_t phase_counts [6];
		count_t count_pick;
		int     leftover;
		phase_counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2};
		arst_n          = 1'b0;
		job.valid       = 1'b0;
		job.job_weight  = '0;
		job.start_batch = 1'b0;
		result.ready    = 1'b0;
		cfg.valid       = 1'b0;
		cfg.bin_count   = COUNT_RESET;
		foreach (bin_load[i])
			bin_load[i] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Reset setting of 16 bins: ties, extreme weights and a batch restart.
		queue_job(16'h0000, 1'b1);
		queue_job(16'hFFFF, 1'b0);
		queue_job(16'h0001, 1'b0);
		queue_job(16'h0000, 1'b0);
		queue_job(16'h0000, 1'b0);
		queue_job(16'h8000, 1'b0);
		queue_job(16'hFFFF, 1'b1);
		wait_idle();

		// A count of zero behaves as a single bin.
		write_bin_count(5'd0);
		queue_job(16'h00FF, 1'b0);
		queue_job(16'hFF00, 1'b0);
		queue_job(16'h0001, 1'b0);
		wait_idle();

		// Counts above the bin total are clipped to all bins.
		write_bin_count(5'd31);
		queue_job(16'h5555, 1'b0);
		queue_job(16'hAAAA, 1'b0);
		wait_idle();
		write_bin_count(5'd17);
		queue_job(16'h0003, 1'b0);
		queue_job(16'h1234, 1'b0);
		wait_idle();

		// Bins left out keep their loads until a batch start clears them all.
		write_bin_count(5'd4);
		queue_job(16'h7FFF, 1'b0);
		queue_job(16'h0010, 1'b0);
		wait_idle();
		write_bin_count(5'd16);
		queue_job(16'h0002, 1'b0);
		queue_job(16'h0004, 1'b0);
		queue_job(16'h0008, 1'b1);
		wait_idle();

		// Keep offering requests while the output side is held off.
		hold_request = 1'b1;
		repeat (30) queue_job(random_weight(), $urandom_range(0, 19) == 0);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase < 6)
				count_pick = phase_counts[phase];
			else
				count_pick = count_t'($urandom_range(0, 31));
			write_bin_count(count_pick);
			for (int n = 0; n < PHASE_JOBS; n++)
				queue_job(random_weight(), n == 0 || $urandom_range(0, 24) == 0);
			wait_idle();
		end

		leftover = expected_assignments.size();
		$display("Assigned %0d jobs and checked %0d results over %0d bin count writes,",
			jobs_taken, results_seen, settings_used);
		$display("including a long output stall, batch restarts and out-of-range bin counts.");
		if (mismatches == 0 && leftover == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, leftover);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lla_pkg.sv
design/lla_if.sv
design/lla_cell.sv
design/lla_scan.sv
design/least_loaded_bin_assigner.sv
test/tb_top.sv
